@@ design/jmc_pkg.sv @@
`default_nettype none

package jmc_pkg;

   localparam int AXIS_W    = 16;
   localparam int SPEED_W   = 17;
   localparam int DZ_W      = 15;
   localparam int CFG_W     = 16;
   localparam int NUM_W     = 32;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_IDX_W = 2;

   localparam logic [DZ_W-1:0]  DZ_FULL      = 15'h7fff;
   localparam logic [DZ_W-1:0]  RST_DEADZONE = 15'd1200;
   localparam logic [CFG_W-1:0] RST_MAX_SPD  = 16'd40000;
   localparam logic [CFG_W-1:0] RST_BTN_SPD  = 16'd10000;
   localparam logic [CFG_W-1:0] RST_TIMEOUT  = 16'd500;

   localparam logic [CSR_IDX_W-1:0] CSR_DEADZONE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BTN_SPD  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 2'd3;

   localparam logic REQ_PACKET = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_FIN   = 4'b1000
   } state_type;

   // magnitude plus sign to a 17-bit two's complement speed
   function automatic logic [SPEED_W-1:0] apply_sign(input logic neg,
                                                     input logic [CFG_W-1:0] mag);
      logic [SPEED_W-1:0] ext;
      ext = {1'b0, mag};
      apply_sign = neg ? (~ext + 17'd1) : ext;
   endfunction

endpackage

`default_nettype wire

@@ design/jmc_div.sv @@
`default_nettype none

module jmc_div
   import jmc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DZ_W-1:0]  divisor,
   output logic                  busy,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DZ_W-1:0]  rem_ff, rem_in;
   logic [DZ_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DZ_W:0]    shifted;
   logic [DZ_W:0]    diff;
   logic             ge;

   // one restoring step per cycle; dividend shifts out of the top of quo_ff
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DZ_W-1:0] : shifted[DZ_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ design/joystick_motor_command_core.sv @@
`default_nettype none

// Packet: the left axis, then the right, each passes through one shared
// 32-step restoring divider; an axis in the deadzone or at full deadzone
// skips the divider. The next word is accepted once the result loads into
// the output register, not while the result waits for the output to free.
// Tick: a silent tick leaves the block idle; a failsafe tick goes to the result.
// Reset (synchronous, active high): register defaults; clears history, valids.
module joystick_motor_command_core
   import jmc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // left_y[15:0], right_y[31:16], button_word[47:32]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[0]
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // speed_left[16:0], speed_right[33:17], speed_aux[50:34],
   // fx_start[51], fx_stop[52], zero[55:53]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // failsafe[0]
   output logic                       rsp_tuser,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_W-1:0]      csr_data
);

   state_type            state_ff, state_in;
   logic                 axis_ff, axis_in;
   logic [AXIS_W-1:0]    ly_ff, ly_in;
   logic [AXIS_W-1:0]    ry_ff, ry_in;
   logic                 neg_ff, neg_in;
   logic [SPEED_W-1:0]   spd_l_ff, spd_l_in;
   logic [SPEED_W-1:0]   spd_r_ff, spd_r_in;
   logic [SPEED_W-1:0]   aux_ff, aux_in;
   logic                 fxs_ff, fxs_in;
   logic                 fxp_ff, fxp_in;
   logic                 fail_ff, fail_in;
   logic [AXIS_W-1:0]    prev_btn_ff, prev_btn_in;
   logic [CFG_W-1:0]     sil_ff, sil_in;
   logic [DZ_W-1:0]      dz_ff, dz_in;
   logic [CFG_W-1:0]     max_ff, max_in;
   logic [CFG_W-1:0]     bspd_ff, bspd_in;
   logic [CFG_W-1:0]     tmo_ff, tmo_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_fail_ff, rsp_fail_in;

   logic                 req_acc;
   logic                 csr_acc;
   logic                 out_free;
   logic [AXIS_W-1:0]    btn;
   logic [AXIS_W-1:0]    rise;
   logic [CFG_W-1:0]     amag;
   logic [CFG_W-1:0]     sil_inc;

   logic [AXIS_W-1:0]    axis_raw;
   logic [SPEED_W-1:0]   v17;
   logic [SPEED_W-1:0]   mag17;
   logic [CFG_W-1:0]     mag;
   logic [CFG_W-1:0]     diff;
   logic [NUM_W-1:0]     product;
   logic [CFG_W-1:0]     clamped;
   logic [SPEED_W-1:0]   axis_res;
   logic                 axis_res_valid;

   logic                 div_start;
   logic                 div_busy;
   logic                 div_done;
   logic [NUM_W-1:0]     div_quo;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_acc    = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign btn     = req_tdata[47:32];
   assign rise    = btn & ~prev_btn_ff;
   assign amag    = (bspd_ff > max_ff) ? max_ff : bspd_ff;
   assign sil_inc = (sil_ff == '1) ? sil_ff : sil_ff + 1'b1;

   // current axis: left is negated, done at 17 bits so -32768 maps to +32768
   always_comb begin
      axis_raw = axis_ff ? ry_ff : ly_ff;
      v17      = {axis_raw[AXIS_W-1], axis_raw};
      if (!axis_ff) begin
         v17 = ~v17 + 17'd1;
      end
      mag17    = v17[SPEED_W-1] ? (~v17 + 17'd1) : v17;
      mag      = mag17[CFG_W-1:0];
      diff     = mag - {1'b0, dz_ff};
      product  = diff * max_ff;
      clamped  = (div_quo > {16'd0, max_ff}) ? max_ff : div_quo[CFG_W-1:0];
   end

   jmc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (DZ_FULL - dz_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      ly_in        = ly_ff;
      ry_in        = ry_ff;
      neg_in       = neg_ff;
      spd_l_in     = spd_l_ff;
      spd_r_in     = spd_r_ff;
      aux_in       = aux_ff;
      fxs_in       = fxs_ff;
      fxp_in       = fxp_ff;
      fail_in      = fail_ff;
      prev_btn_in  = prev_btn_ff;
      sil_in       = sil_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_fail_in  = rsp_fail_ff;
      div_start    = 1'b0;
      axis_res       = '0;
      axis_res_valid = 1'b0;

      dz_in   = dz_ff;
      max_in  = max_ff;
      bspd_in = bspd_ff;
      tmo_in  = tmo_ff;
      if (csr_acc) begin
         case (csr_index)
            CSR_DEADZONE: dz_in   = csr_data[DZ_W-1:0];
            CSR_MAX_SPD:  max_in  = csr_data;
            CSR_BTN_SPD:  bspd_in = csr_data;
            CSR_TIMEOUT:  tmo_in  = csr_data;
            default:      dz_in   = dz_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == REQ_TICK) begin
                  sil_in = sil_inc;
                  if (sil_inc > tmo_ff) begin
                     spd_l_in = '0;
                     spd_r_in = '0;
                     aux_in   = '0;
                     fxs_in   = 1'b0;
                     fxp_in   = 1'b0;
                     fail_in  = 1'b1;
                     state_in = ST_FIN;
                  end
               end else begin
                  ly_in       = req_tdata[15:0];
                  ry_in       = req_tdata[31:16];
                  fxs_in      = rise[0];
                  fxp_in      = rise[1];
                  fail_in     = 1'b0;
                  prev_btn_in = btn;
                  sil_in      = '0;
                  axis_in     = 1'b0;
                  if (btn[2] && !btn[3]) begin
                     aux_in = apply_sign(1'b0, amag);
                  end else if (!btn[2] && btn[3]) begin
                     aux_in = apply_sign(1'b1, amag);
                  end else begin
                     aux_in = '0;
                  end
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            neg_in = v17[SPEED_W-1];
            if (mag < {1'b0, dz_ff}) begin
               axis_res_valid = 1'b1;
            end else if (dz_ff == DZ_FULL) begin
               axis_res       = apply_sign(v17[SPEED_W-1], max_ff);
               axis_res_valid = 1'b1;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               axis_res       = apply_sign(neg_ff, clamped);
               axis_res_valid = 1'b1;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, fxp_ff, fxs_ff, aux_ff, spd_r_ff, spd_l_ff};
               rsp_fail_in  = fail_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // finished axis: store and move on to the right axis or the result
      if (axis_res_valid) begin
         if (!axis_ff) begin
            spd_l_in = axis_res;
            axis_in  = 1'b1;
            state_in = ST_SETUP;
         end else begin
            spd_r_in = axis_res;
            state_in = ST_FIN;
         end
      end
   end

   always_ff @(posedge clock) begin
      ly_ff       <= ly_in;
      ry_ff       <= ry_in;
      neg_ff      <= neg_in;
      spd_l_ff    <= spd_l_in;
      spd_r_ff    <= spd_r_in;
      aux_ff      <= aux_in;
      fxs_ff      <= fxs_in;
      fxp_ff      <= fxp_in;
      fail_ff     <= fail_in;
      rsp_data_ff <= rsp_data_in;
      rsp_fail_ff <= rsp_fail_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 1'b0;
         prev_btn_ff  <= '0;
         sil_ff       <= '0;
         dz_ff        <= RST_DEADZONE;
         max_ff       <= RST_MAX_SPD;
         bspd_ff      <= RST_BTN_SPD;
         tmo_ff       <= RST_TIMEOUT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         prev_btn_ff  <= prev_btn_in;
         sil_ff       <= sil_in;
         dz_ff        <= dz_in;
         max_ff       <= max_in;
         bspd_ff      <= bspd_in;
         tmo_ff       <= tmo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_fail_ff;

`ifndef SYNTHESIS
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("failsafe word carries nonzero payload");

   a_pkt_setup: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_tuser == REQ_PACKET) |=> state_ff == ST_SETUP && !axis_ff)
      else $error("packet did not start on the left axis");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == ST_DIV)
      else $error("divider running outside the divide state");

   a_done_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> $past(div_busy))
      else $error("divider done without a running division");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_joystick_motor_command_core.sv @@
`default_nettype none

module tb_joystick_motor_command_core;
   import jmc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 120;
   localparam int CYCLE_LIMIT   = 2_000_000;

   typedef struct packed {
      logic               typ;
      logic signed [15:0] left_y;
      logic signed [15:0] right_y;
      logic [15:0]        buttons;
   } joy_req_t;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_left;
      logic [SPEED_W-1:0] speed_right;
      logic [SPEED_W-1:0] speed_aux;
      logic               fx_start;
      logic               fx_stop;
      logic               failsafe;
   } motor_cmd_t;

   class motor_cmd_scoreboard;
      logic [DZ_W-1:0]  deadzone;
      logic [CFG_W-1:0] max_spd;
      logic [CFG_W-1:0] btn_spd;
      logic [CFG_W-1:0] timeout_ticks;
      logic [15:0]      prev_buttons;
      logic [15:0]      silence;
      motor_cmd_t       pending_cmds[$];
      int               mismatches;

      function new();
         deadzone      = RST_DEADZONE;
         max_spd       = RST_MAX_SPD;
         btn_spd       = RST_BTN_SPD;
         timeout_ticks = RST_TIMEOUT;
         prev_buttons  = '0;
         silence       = '0;
         mismatches    = 0;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
         case (idx)
            CSR_DEADZONE: deadzone = val[DZ_W-1:0];
            CSR_MAX_SPD:  max_spd = val;
            CSR_BTN_SPD:  btn_spd = val;
            CSR_TIMEOUT:  timeout_ticks = val;
            default: ;
         endcase
      endfunction

      // v is already negated for the left stick, so -32768 shows up as +32768
      function int scale_axis(input int v);
         int     mag;
         int     dz;
         int     mx;
         int     sat;
         longint q;
         mag = (v < 0) ? -v : v;
         dz  = deadzone;
         mx  = max_spd;
         if (mag < dz)
            return 0;
         if (dz >= 32767) begin
            sat = mx;
         end else begin
            q   = (longint'(mag - dz) * mx) / (32767 - dz);
            sat = (q > mx) ? mx : int'(q);
         end
         return (v < 0) ? -sat : sat;
      endfunction

      function void note_request(input joy_req_t r);
         motor_cmd_t  c;
         int          ly;
         int          ry;
         int          amag;
         int          aux;
         logic [15:0] rise;
         c = '0;
         if (r.typ == REQ_TICK) begin
            if (silence != 16'hffff)
               silence++;
            if (silence > timeout_ticks) begin
               c.failsafe = 1'b1;
               pending_cmds.push_back(c);
            end
         end else begin
            ly   = r.left_y;
            ry   = r.right_y;
            rise = r.buttons & ~prev_buttons;
            amag = (btn_spd > max_spd) ? int'(max_spd) : int'(btn_spd);
            aux  = 0;
            if (r.buttons[2] && !r.buttons[3])
               aux = amag;
            else if (!r.buttons[2] && r.buttons[3])
               aux = -amag;
            c.speed_left  = SPEED_W'(scale_axis(-ly));
            c.speed_right = SPEED_W'(scale_axis(ry));
            c.speed_aux   = SPEED_W'(aux);
            c.fx_start    = rise[0];
            c.fx_stop     = rise[1];
            pending_cmds.push_back(c);
            prev_buttons = r.buttons;
            silence      = '0;
         end
      endfunction

      function string show(input motor_cmd_t c);
         return $sformatf("left=%0d right=%0d aux=%0d start=%b stop=%b failsafe=%b",
                          $signed(c.speed_left), $signed(c.speed_right),
                          $signed(c.speed_aux), c.fx_start, c.fx_stop, c.failsafe);
      endfunction

      function void check_command(input motor_cmd_t got);
         motor_cmd_t want;
         if (pending_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected command word: %s", show(got));
         end else begin
            want = pending_cmds.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("command mismatch\n  exp %s\n  got %s", show(want), show(got));
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CFG_W-1:0]      csr_data = '0;

   motor_cmd_scoreboard sb = new();

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          sent_items = 0;
   int          hold_left = 0;
   bit          hold_req = 1'b0;
   logic [15:0] btn_hist = '0;

   joystick_motor_command_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: random backpressure, or a long hold-off when asked for
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = 600;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_command(motor_cmd_t'({rsp_tdata[16:0], rsp_tdata[33:17], rsp_tdata[50:34],
                                        rsp_tdata[51], rsp_tdata[52], rsp_tuser}));
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic joy_req_t pkt(input int l, input int r, input int b);
      joy_req_t q;
      q.typ     = REQ_PACKET;
      q.left_y  = 16'(l);
      q.right_y = 16'(r);
      q.buttons = 16'(b);
      return q;
   endfunction

   // axis payload is ignored on ticks but still toggled
   function automatic joy_req_t tick_req();
      joy_req_t q;
      q.typ     = REQ_TICK;
      q.left_y  = 16'($urandom_range(65535));
      q.right_y = 16'($urandom_range(65535));
      q.buttons = 16'($urandom_range(65535));
      return q;
   endfunction

   function automatic int rand_axis(input int dz);
      int k;
      int v;
      k = $urandom_range(99);
      if (k < 10) begin
         case ($urandom_range(2))
            0: v = -32768;
            1: v = 32767;
            default: v = -32767;
         endcase
      end else if (k < 35) begin
         v = dz + int'($urandom_range(4)) - 2;
         if ($urandom_range(1))
            v = -v;
         if (v > 32767)
            v = 32767;
         if (v < -32768)
            v = -32768;
      end else begin
         v = int'($urandom_range(65535)) - 32768;
      end
      return v;
   endfunction

   task automatic send_req(input joy_req_t r);
      if (sent_items < 600) begin
         send_idle_pct = 22;
         recv_idle_pct = 74;
      end else if (sent_items < 1200) begin
         send_idle_pct = 74;
         recv_idle_pct = 22;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.typ;
      req_tdata  <= {r.buttons, r.right_y, r.left_y};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(r);
      sent_items++;
      @(negedge clock);
   endtask

   // ticks may leave no word behind, so give the block time to go idle
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic set_config(input int dz, input int mx, input int bs, input int to);
      settle();
      write_csr(CSR_DEADZONE, CFG_W'(dz));
      write_csr(CSR_MAX_SPD, CFG_W'(mx));
      write_csr(CSR_BTN_SPD, CFG_W'(bs));
      write_csr(CSR_TIMEOUT, CFG_W'(to));
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int n, input int hold_at, input int pause_at);
      int          i;
      int          k;
      int          len;
      int          dz;
      int          burst_max;
      logic [15:0] b;
      i = 0;
      dz = sb.deadzone;
      burst_max = (sb.timeout_ticks <= 40) ? int'(sb.timeout_ticks) + 4 : 8;
      while (i < n) begin
         if (hold_at >= 0 && i >= hold_at) begin
            hold_req = 1'b1;
            hold_at  = -1;
         end
         if (pause_at >= 0 && i >= pause_at) begin
            settle();
            pause_at = -1;
         end
         k = $urandom_range(99);
         if (k < 60) begin
            // half the time only the four defined buttons move
            if ($urandom_range(1))
               b = {btn_hist[15:4], 4'($urandom_range(15))};
            else
               b = 16'($urandom_range(65535));
            btn_hist = b;
            send_req(pkt(rand_axis(dz), rand_axis(dz), b));
            i++;
         end else if (k < 85) begin
            send_req(tick_req());
            i++;
         end else begin
            // tick runs; with a timeout of 40 or less they can cross the silence timeout
            len = $urandom_range(burst_max, 1);
            repeat (len) send_req(tick_req());
            i += len;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: extremes, deadzone edges, button edges
      send_req(pkt(-32768, 32767, 0));
      send_req(pkt(32767, -32768, 1));
      send_req(pkt(0, 0, 2));
      send_req(pkt(-32767, 1, 3));
      send_req(pkt(1, -1, 0));
      send_req(pkt(100, 200, 3));
      send_req(pkt(1199, -1199, 4));
      send_req(pkt(-1200, 1200, 8));
      send_req(pkt(1201, -1201, 12));
      send_req(pkt(-1, 16000, 16'hffff));
      send_req(tick_req());
      send_req(tick_req());
      send_req(pkt(-20000, 20000, 16'hfff0));

      // aux speed above max gets clamped; short timeout trips failsafe
      set_config(1200, 5000, 9000, 2);
      send_req(pkt(30000, -30000, 4));
      repeat (4) send_req(tick_req());
      send_req(pkt(0, 0, 8));
      repeat (3) send_req(tick_req());

      // full deadzone: divisor would be zero
      set_config(DZ_FULL, 65535, 65535, 0);
      send_req(pkt(-32768, 32766, 4));
      send_req(pkt(32767, -32767, 8));
      send_req(tick_req());
      send_req(tick_req());

      set_config(RST_DEADZONE, RST_MAX_SPD, RST_BTN_SPD, RST_TIMEOUT);
      run_random(295, -1, -1);
      set_config(0, 65535, 40000, 0);
      run_random(295, 150, -1);
      set_config(DZ_FULL, 65535, 0, 3);
      run_random(295, -1, -1);
      set_config(32766, 1, 2, 10);
      run_random(295, -1, 140);
      set_config($urandom_range(32767), $urandom_range(65535), $urandom_range(65535),
                 $urandom_range(20));
      run_random(295, -1, -1);
      set_config($urandom_range(32767), 0, $urandom_range(65535), $urandom_range(20));
      run_random(295, -1, -1);

      settle();
      if (sb.mismatches == 0 && sb.pending_cmds.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
